@@ sv/dcvp_pkg.sv @@
package dcvp_pkg;

  localparam int VAL_W = 16;
  localparam int CNT_W = 4;
  localparam int DSR_W = VAL_W + 1;
  localparam logic [VAL_W-1:0] THR_RESET = 16'hFFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DLOAD,
    S_DIV_EDGE,
    S_ACCUM,
    S_MLOAD,
    S_DIV_MEAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mult;
    logic load_edge;
    logic load_mean;
    logic div_step;
    logic accum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic hit;
    logic last;
    logic hits_zero;
    logic out_free;
  } status_t;

endpackage

@@ sv/dcvp_ifs.sv @@
interface dcvp_in_if import dcvp_pkg::*; #(parameter int POS_WIDTH = 20);
  logic                        valid;
  logic                        ready;
  logic signed [VAL_W-1:0]     signed_a;
  logic        [VAL_W-1:0]     unsigned_a;
  logic signed [VAL_W-1:0]     signed_b;
  logic        [VAL_W-1:0]     unsigned_b;
  logic signed [POS_WIDTH-1:0] pos_a_x;
  logic signed [POS_WIDTH-1:0] pos_a_y;
  logic signed [POS_WIDTH-1:0] pos_a_z;
  logic signed [POS_WIDTH-1:0] pos_b_x;
  logic signed [POS_WIDTH-1:0] pos_b_y;
  logic signed [POS_WIDTH-1:0] pos_b_z;
  logic                        last_edge;

  modport source (
    output valid, signed_a, unsigned_a, signed_b, unsigned_b,
    output pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, last_edge,
    input  ready
  );
  modport sink (
    input  valid, signed_a, unsigned_a, signed_b, unsigned_b,
    input  pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, last_edge,
    output ready
  );
endinterface

interface dcvp_out_if import dcvp_pkg::*; #(parameter int POS_WIDTH = 20);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] vertex_x;
  logic signed [POS_WIDTH-1:0] vertex_y;
  logic signed [POS_WIDTH-1:0] vertex_z;
  logic        [CNT_W-1:0]     crossing_count;
  logic                        has_surface;

  modport source (
    output valid, vertex_x, vertex_y, vertex_z, crossing_count, has_surface,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, vertex_z, crossing_count, has_surface,
    output ready
  );
endinterface

interface dcvp_cfg_if import dcvp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/dcvp_ctrl.sv @@
module dcvp_ctrl import dcvp_pkg::*; #(
  parameter int POS_WIDTH = 20
) (
  input  logic    clk,
  input  logic    rst,
  input  status_t st,
  output cmd_t    cmd,
  output logic    in_ready
);

  localparam int QW = POS_WIDTH + 1;
  localparam int CW = $clog2(QW);

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (st.in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.hit) begin
          state_next = S_DLOAD;
        end else if (st.last) begin
          state_next = st.hits_zero ? S_EMIT : S_MLOAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DLOAD: begin
        cnt_next   = CW'(QW - 1);
        state_next = S_DIV_EDGE;
      end
      S_DIV_EDGE: begin
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        state_next = st.last ? S_MLOAD : S_IDLE;
      end
      S_MLOAD: begin
        cnt_next   = CW'(QW - 1);
        state_next = S_DIV_MEAN;
      end
      S_DIV_MEAN: begin
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = st.in_valid;
      end
      S_EVAL:     cmd.mult      = 1'b1;
      S_DLOAD:    cmd.load_edge = 1'b1;
      S_DIV_EDGE: cmd.div_step  = 1'b1;
      S_ACCUM:    cmd.accum     = 1'b1;
      S_MLOAD:    cmd.load_mean = 1'b1;
      S_DIV_MEAN: cmd.div_step  = 1'b1;
      S_EMIT:     cmd.emit      = st.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_capture_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_EVAL)
    else $error("captured word not evaluated");

  a_div_to_accum: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_EDGE && cnt == '0) |=> cmd.accum)
    else $error("edge division did not end in accumulation");

  a_accum_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.accum |=> !st.hits_zero)
    else $error("accumulation did not count a crossing");

endmodule

@@ sv/dcvp_datapath.sv @@
module dcvp_datapath import dcvp_pkg::*; #(
  parameter int EDGES_PER_CELL = 12,
  parameter int POS_WIDTH      = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  input  logic         in_ready,
  output status_t      st,
  dcvp_in_if.sink      edge_in,
  dcvp_out_if.source   vertex_out,
  dcvp_cfg_if.sink     cfg
);

  localparam int PW = POS_WIDTH;
  localparam int QW = PW + 1;
  localparam int SW = PW + 4;
  localparam int MW = QW + VAL_W;
  localparam int DW = QW + DSR_W;

  logic [VAL_W-1:0]        threshold;
  logic [CNT_W-1:0]        hits;
  logic signed [SW-1:0]    sum [3];
  logic                    hit;
  logic                    last;
  logic [VAL_W-1:0]        a_mag;
  logic [DSR_W-1:0]        den;
  logic [DSR_W-1:0]        dsr;
  logic signed [PW-1:0]    pa [3];
  logic signed [PW-1:0]    pb [3];
  logic [MW-1:0]           prod [3];
  logic                    neg [3];
  logic [DSR_W-1:0]        rem [3];
  logic [QW-1:0]           qr [3];
  logic                    out_valid;
  logic signed [PW-1:0]    vx [3];
  logic [CNT_W-1:0]        out_count;
  logic                    out_surface;

  logic signed [VAL_W-1:0] in_a;
  logic signed [VAL_W-1:0] in_b;
  logic [VAL_W-1:0]        in_a_mag;
  logic [VAL_W-1:0]        in_b_mag;
  logic                    flips;
  logic                    both_far;
  logic                    hit_next;
  logic signed [PW-1:0]    in_pa [3];
  logic signed [PW-1:0]    in_pb [3];
  logic signed [QW-1:0]    diff [3];
  logic [QW-1:0]           diff_mag [3];
  logic [DW-1:0]           dvd_edge [3];
  logic [DW-1:0]           dvd_mean [3];
  logic [SW-1:0]           sum_mag [3];
  logic [DSR_W:0]          trial [3];
  logic                    ge [3];
  logic [DSR_W-1:0]        rem_next [3];
  logic [SW-1:0]           q_ext [3];
  logic [SW-1:0]           offset [3];
  logic [QW-1:0]           q_signed [3];

  assign edge_in.ready = in_ready;
  assign cfg.ready     = 1'b1;

  assign in_a     = edge_in.signed_a;
  assign in_b     = edge_in.signed_b;
  assign in_a_mag = in_a[VAL_W-1] ? VAL_W'(-in_a) : in_a;
  assign in_b_mag = in_b[VAL_W-1] ? VAL_W'(-in_b) : in_b;
  assign flips    = (in_a < 0 && in_b > 0) || (in_a > 0 && in_b < 0);
  assign both_far = (edge_in.unsigned_a > threshold) && (edge_in.unsigned_b > threshold);
  assign hit_next = flips && !both_far && (hits < CNT_W'(EDGES_PER_CELL));

  assign in_pa[0] = edge_in.pos_a_x;
  assign in_pa[1] = edge_in.pos_a_y;
  assign in_pa[2] = edge_in.pos_a_z;
  assign in_pb[0] = edge_in.pos_b_x;
  assign in_pb[1] = edge_in.pos_b_y;
  assign in_pb[2] = edge_in.pos_b_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]     = {pb[k][PW-1], pb[k]} - {pa[k][PW-1], pa[k]};
      diff_mag[k] = diff[k][QW-1] ? QW'(-diff[k]) : diff[k];
      dvd_edge[k] = DW'(prod[k]) + DW'(den >> 1);
      sum_mag[k]  = sum[k][SW-1] ? SW'(-sum[k]) : sum[k];
      dvd_mean[k] = DW'(sum_mag[k]) + DW'(hits >> 1);
      trial[k]    = {rem[k], qr[k][QW-1]};
      ge[k]       = trial[k] >= {1'b0, dsr};
      rem_next[k] = ge[k] ? DSR_W'(trial[k] - {1'b0, dsr}) : trial[k][DSR_W-1:0];
      q_ext[k]    = SW'(qr[k]);
      offset[k]   = neg[k] ? SW'(-q_ext[k]) : q_ext[k];
      q_signed[k] = neg[k] ? QW'(-qr[k]) : qr[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg.valid) begin
      threshold <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit   <= hit_next;
      last  <= edge_in.last_edge;
      a_mag <= in_a_mag;
      den   <= DSR_W'(in_a_mag) + DSR_W'(in_b_mag);
      for (int k = 0; k < 3; k++) begin
        pa[k] <= in_pa[k];
        pb[k] <= in_pb[k];
      end
    end
    if (cmd.mult) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= MW'(diff_mag[k]) * MW'(a_mag);
        neg[k]  <= diff[k][QW-1];
      end
    end
    if (cmd.load_edge) begin
      dsr <= den;
      for (int k = 0; k < 3; k++) begin
        rem[k] <= dvd_edge[k][DW-1:QW];
        qr[k]  <= dvd_edge[k][QW-1:0];
      end
    end
    if (cmd.load_mean) begin
      dsr <= DSR_W'(hits);
      for (int k = 0; k < 3; k++) begin
        rem[k] <= dvd_mean[k][DW-1:QW];
        qr[k]  <= dvd_mean[k][QW-1:0];
        neg[k] <= sum[k][SW-1];
      end
    end
    if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        rem[k] <= rem_next[k];
        qr[k]  <= {qr[k][QW-2:0], ge[k]};
      end
    end
    if (cmd.emit) begin
      out_count   <= hits;
      out_surface <= (hits != '0);
      for (int k = 0; k < 3; k++) begin
        vx[k] <= (hits == '0) ? '0 : q_signed[k][PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits <= '0;
      for (int k = 0; k < 3; k++) begin
        sum[k] <= '0;
      end
    end else if (cmd.emit) begin
      hits <= '0;
      for (int k = 0; k < 3; k++) begin
        sum[k] <= '0;
      end
    end else if (cmd.accum) begin
      hits <= hits + 1'b1;
      for (int k = 0; k < 3; k++) begin
        sum[k] <= sum[k] + {{(SW-PW){pa[k][PW-1]}}, pa[k]} + offset[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (vertex_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign vertex_out.valid          = out_valid;
  assign vertex_out.vertex_x       = vx[0];
  assign vertex_out.vertex_y       = vx[1];
  assign vertex_out.vertex_z       = vx[2];
  assign vertex_out.crossing_count = out_count;
  assign vertex_out.has_surface    = out_surface;

  assign st.in_valid  = edge_in.valid;
  assign st.hit       = hit;
  assign st.last      = last;
  assign st.hits_zero = (hits == '0);
  assign st.out_free  = !out_valid || vertex_out.ready;

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !vertex_out.ready))
    else $error("result overwritten before it was taken");

  a_cap_hits: assert property (@(posedge clk) disable iff (rst)
    cmd.accum |-> hits < CNT_W'(EDGES_PER_CELL))
    else $error("crossing count exceeds cell edge count");

  a_flag_count: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid && (out_surface == (out_count != '0)))
    else $error("surface flag disagrees with crossing count");

endmodule

@@ sv/dual_cell_vertex_placement.sv @@
// Places one surface-nets vertex per dual cell. Edges arrive one word at a time; an edge whose
// signed values strictly change sign, with at least one unsigned value at or below the
// threshold, adds its interpolated crossing point to per-axis sums (at most EDGES_PER_CELL per
// cell), and the word flagged last_edge produces one result with the rounded mean point, the
// crossing count and the surface flag. Each edge is handled in full, through its division if it
// crosses, before the next is taken. All divisions run on the shared restoring divider, which
// retires one quotient bit per cycle on all three axes at once for both the edge fraction and
// the final mean. The block takes new edges while a result waits in its output register.
module dual_cell_vertex_placement import dcvp_pkg::*; #(
  parameter int EDGES_PER_CELL = 12,
  parameter int POS_WIDTH      = 20
) (
  input  logic       clk,
  input  logic       rst,
  dcvp_in_if.sink    edge_in,
  dcvp_out_if.source vertex_out,
  dcvp_cfg_if.sink   cfg
);

  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  dcvp_ctrl #(
    .POS_WIDTH (POS_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  dcvp_datapath #(
    .EDGES_PER_CELL (EDGES_PER_CELL),
    .POS_WIDTH      (POS_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_ready   (in_ready),
    .st         (st),
    .edge_in    (edge_in),
    .vertex_out (vertex_out),
    .cfg        (cfg)
  );

endmodule

@@ sim/dcvp_vertex_checker.sv @@
module dcvp_vertex_checker import dcvp_pkg::*; #(
  parameter int EDGES_PER_CELL = 12,
  parameter int POS_WIDTH      = 20
) (
  input  logic clk,
  input  logic rst,
  dcvp_in_if   edge_in,
  dcvp_out_if  vertex_out,
  dcvp_cfg_if  cfg,
  output int   fail_count,
  output int   pending,
  output int   cells_seen,
  output int   surfaces_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] x;
    logic signed [POS_WIDTH-1:0] y;
    logic signed [POS_WIDTH-1:0] z;
    logic [CNT_W-1:0]            count;
    logic                        surface;
  } vertex_t;

  vertex_t          expected_vertices[$];
  logic [VAL_W-1:0] threshold;
  longint           crossing_sum[3];
  int               crossing_hits;

  function automatic longint nearest_quotient(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  task automatic absorb_edge();
    longint  a;
    longint  b;
    longint  ma;
    longint  mb;
    longint  pa[3];
    longint  pb[3];
    logic    both_far;
    logic    flips;
    vertex_t v;
    a = longint'(edge_in.signed_a);
    b = longint'(edge_in.signed_b);
    pa[0] = longint'(edge_in.pos_a_x);
    pa[1] = longint'(edge_in.pos_a_y);
    pa[2] = longint'(edge_in.pos_a_z);
    pb[0] = longint'(edge_in.pos_b_x);
    pb[1] = longint'(edge_in.pos_b_y);
    pb[2] = longint'(edge_in.pos_b_z);
    both_far = (edge_in.unsigned_a > threshold) && (edge_in.unsigned_b > threshold);
    flips = (a < 0 && b > 0) || (a > 0 && b < 0);
    if (!both_far && flips && crossing_hits < EDGES_PER_CELL) begin
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      for (int k = 0; k < 3; k++) begin
        crossing_sum[k] += pa[k] + nearest_quotient((pb[k] - pa[k]) * ma, ma + mb);
      end
      crossing_hits++;
    end
    if (edge_in.last_edge) begin
      v = '0;
      if (crossing_hits != 0) begin
        v.x       = POS_WIDTH'(nearest_quotient(crossing_sum[0], longint'(crossing_hits)));
        v.y       = POS_WIDTH'(nearest_quotient(crossing_sum[1], longint'(crossing_hits)));
        v.z       = POS_WIDTH'(nearest_quotient(crossing_sum[2], longint'(crossing_hits)));
        v.count   = CNT_W'(crossing_hits);
        v.surface = 1'b1;
      end
      expected_vertices.insert(expected_vertices.size(), v);
      cells_seen++;
      if (v.surface) surfaces_seen++;
      crossing_sum  = '{0, 0, 0};
      crossing_hits = 0;
    end
  endtask

  task automatic check_vertex();
    vertex_t exp_v;
    if (expected_vertices.size() == 0) begin
      $error("vertex word with none expected: x %0d y %0d z %0d count %0d surface %0d",
             vertex_out.vertex_x, vertex_out.vertex_y, vertex_out.vertex_z,
             vertex_out.crossing_count, vertex_out.has_surface);
      fail_count++;
    end else begin
      exp_v = expected_vertices.pop_front();
      if (vertex_out.vertex_x !== exp_v.x) begin
        $error("vertex_x: expected %0d, got %0d", exp_v.x, vertex_out.vertex_x);
        fail_count++;
      end
      if (vertex_out.vertex_y !== exp_v.y) begin
        $error("vertex_y: expected %0d, got %0d", exp_v.y, vertex_out.vertex_y);
        fail_count++;
      end
      if (vertex_out.vertex_z !== exp_v.z) begin
        $error("vertex_z: expected %0d, got %0d", exp_v.z, vertex_out.vertex_z);
        fail_count++;
      end
      if (vertex_out.crossing_count !== exp_v.count) begin
        $error("crossing_count: expected %0d, got %0d", exp_v.count, vertex_out.crossing_count);
        fail_count++;
      end
      if (vertex_out.has_surface !== exp_v.surface) begin
        $error("has_surface: expected %0d, got %0d", exp_v.surface, vertex_out.has_surface);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      threshold     = THR_RESET;
      crossing_sum  = '{0, 0, 0};
      crossing_hits = 0;
      expected_vertices.delete();
      fail_count    = 0;
      pending       = 0;
      cells_seen    = 0;
      surfaces_seen = 0;
    end else begin
      if (vertex_out.valid && vertex_out.ready) check_vertex();
      if (cfg.valid && cfg.ready) threshold = cfg.data;
      if (edge_in.valid && edge_in.ready) absorb_edge();
      pending = expected_vertices.size();
    end
  end

endmodule

@@ sim/tb_dual_cell_vertex_placement.sv @@
module tb_dual_cell_vertex_placement import dcvp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W      = 20;
  localparam int CELL_EDGES = 12;
  localparam int DRAIN_WAIT = 2 * POS_W + 20;
  localparam int LONG_HOLD  = 600;
  localparam int PHASE_WORDS = 210;
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef struct packed {
    logic signed [VAL_W-1:0] sa;
    logic        [VAL_W-1:0] ua;
    logic signed [VAL_W-1:0] sb;
    logic        [VAL_W-1:0] ub;
    logic signed [POS_W-1:0] ax;
    logic signed [POS_W-1:0] ay;
    logic signed [POS_W-1:0] az;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] by;
    logic signed [POS_W-1:0] bz;
    logic                    last;
  } edge_word_t;

  logic             clk;
  logic             rst;
  int               fail_count;
  int               pending;
  int               cells_seen;
  int               surfaces_seen;
  int               edges_sent    = 0;
  int               settings      = 0;
  logic [VAL_W-1:0] cur_thr       = THR_RESET;
  logic             quiet         = 1'b0;
  logic             long_hold_req = 1'b0;

  dcvp_in_if  #(.POS_WIDTH(POS_W)) edge_in ();
  dcvp_out_if #(.POS_WIDTH(POS_W)) vertex_out ();
  dcvp_cfg_if                      cfg ();

  dual_cell_vertex_placement #(
    .EDGES_PER_CELL(CELL_EDGES),
    .POS_WIDTH     (POS_W)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .edge_in   (edge_in),
    .vertex_out(vertex_out),
    .cfg       (cfg)
  );

  dcvp_vertex_checker #(
    .EDGES_PER_CELL(CELL_EDGES),
    .POS_WIDTH     (POS_W)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .edge_in      (edge_in),
    .vertex_out   (vertex_out),
    .cfg          (cfg),
    .fail_count   (fail_count),
    .pending      (pending),
    .cells_seen   (cells_seen),
    .surfaces_seen(surfaces_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  function automatic edge_word_t random_edge();
    edge_word_t e;
    int         neg;
    int         pos;
    int         t;
    logic       tiny;
    e.ax = POS_W'($urandom);
    e.ay = POS_W'($urandom);
    e.az = POS_W'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        e.bx = POS_W'(int'(e.ax) + int'($urandom_range(0, 8191)) - 4096);
        e.by = POS_W'(int'(e.ay) + int'($urandom_range(0, 8191)) - 4096);
        e.bz = POS_W'(int'(e.az) + int'($urandom_range(0, 8191)) - 4096);
      end
      1: begin
        e.ax = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
        e.ay = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
        e.az = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
        e.bx = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
        e.by = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
        e.bz = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
      end
      default: begin
        e.bx = POS_W'($urandom);
        e.by = POS_W'($urandom);
        e.bz = POS_W'($urandom);
      end
    endcase
    case ($urandom_range(0, 9))
      7: begin
        e.sa = VAL_W'($urandom);
        e.sb = VAL_W'($urandom);
        if ($urandom_range(0, 1)) e.sa = '0;
        else e.sb = '0;
      end
      8, 9: begin
        e.sa = VAL_W'($urandom);
        e.sb = VAL_W'($urandom);
      end
      default: begin
        tiny = ($urandom_range(0, 2) == 0);
        neg  = tiny ? $urandom_range(1, 64) : $urandom_range(1, 32768);
        pos  = tiny ? $urandom_range(1, 64) : $urandom_range(1, 32767);
        if ($urandom_range(0, 1)) begin
          e.sa = VAL_W'(-neg);
          e.sb = VAL_W'(pos);
        end else begin
          e.sa = VAL_W'(pos);
          e.sb = VAL_W'(-neg);
        end
      end
    endcase
    e.ua = VAL_W'($urandom);
    e.ub = VAL_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      t = int'(cur_thr) + int'($urandom_range(0, 4)) - 2;
      if (t < 0) t = 0;
      if (t > 65535) t = 65535;
      e.ua = VAL_W'(t);
    end
    if ($urandom_range(0, 3) == 0) begin
      t = int'(cur_thr) + int'($urandom_range(0, 4)) - 2;
      if (t < 0) t = 0;
      if (t > 65535) t = 65535;
      e.ub = VAL_W'(t);
    end
    e.last = 1'b0;
    return e;
  endfunction

  task automatic push_edge(input edge_word_t e);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      edge_in.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    edge_in.valid      <= 1'b1;
    edge_in.signed_a   <= e.sa;
    edge_in.unsigned_a <= e.ua;
    edge_in.signed_b   <= e.sb;
    edge_in.unsigned_b <= e.ub;
    edge_in.pos_a_x    <= e.ax;
    edge_in.pos_a_y    <= e.ay;
    edge_in.pos_a_z    <= e.az;
    edge_in.pos_b_x    <= e.bx;
    edge_in.pos_b_y    <= e.by;
    edge_in.pos_b_z    <= e.bz;
    edge_in.last_edge  <= e.last;
    @(posedge clk);
    while (!edge_in.ready) @(posedge clk);
    edges_sent++;
  endtask

  task automatic wait_drained();
    edge_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [VAL_W-1:0] thr);
    cfg.valid <= 1'b1;
    cfg.data  <= thr;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    cur_thr = thr;
    settings++;
  endtask

  task automatic send_cell(input int len);
    edge_word_t e;
    for (int i = 0; i < len; i++) begin
      e = random_edge();
      e.last = (i == len - 1);
      push_edge(e);
    end
  endtask

  task automatic run_setting(input logic [VAL_W-1:0] thr, input int words);
    int start;
    int pick;
    wait_drained();
    write_threshold(thr);
    start = edges_sent;
    while (edges_sent - start < words) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) send_cell(1);
      else if (pick == 1) send_cell($urandom_range(CELL_EDGES + 1, CELL_EDGES + 4));
      else send_cell($urandom_range(2, CELL_EDGES));
    end
  endtask

  initial begin : sink_side
    vertex_out.ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        vertex_out.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        vertex_out.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        vertex_out.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : source_side
    edge_word_t e;
    rst                <= 1'b1;
    cfg.valid          <= 1'b0;
    cfg.data           <= '0;
    edge_in.valid      <= 1'b0;
    edge_in.signed_a   <= '0;
    edge_in.unsigned_a <= '0;
    edge_in.signed_b   <= '0;
    edge_in.unsigned_b <= '0;
    edge_in.pos_a_x    <= '0;
    edge_in.pos_a_y    <= '0;
    edge_in.pos_a_z    <= '0;
    edge_in.pos_b_x    <= '0;
    edge_in.pos_b_y    <= '0;
    edge_in.pos_b_z    <= '0;
    edge_in.last_edge  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full-scale values and opposite corners of the position range.
    e = '0;
    e.sa = 16'sh8000;
    e.sb = 16'sh7FFF;
    e.ub = 16'hFFFF;
    {e.ax, e.ay, e.az} = {POS_MIN, POS_MIN, POS_MIN};
    {e.bx, e.by, e.bz} = {POS_MAX, POS_MAX, POS_MAX};
    e.last = 1'b1;
    push_edge(e);
    e.sa = 16'sh7FFF;
    e.sb = 16'sh8000;
    {e.ax, e.ay, e.az} = {POS_MAX, POS_MAX, POS_MAX};
    {e.bx, e.by, e.bz} = {POS_MIN, POS_MIN, POS_MIN};
    e.last = 1'b0;
    push_edge(e);
    e = random_edge();
    e.sa = '0;
    e.sb = 16'sd5000;
    e.last = 1'b1;
    push_edge(e);

    // A cell without any crossing: equal signs, then a zero end.
    e = random_edge();
    e.sa = 16'sd100;
    e.sb = 16'sd200;
    push_edge(e);
    e = random_edge();
    e.sa = -16'sd3;
    e.sb = '0;
    e.last = 1'b1;
    push_edge(e);

    // More crossings than the cell can count; the midpoint ties exercise rounding.
    for (int i = 0; i < CELL_EDGES + 2; i++) begin
      e = random_edge();
      e.sa = -16'sd1;
      e.sb = 16'sd1;
      e.last = (i == CELL_EDGES + 1);
      push_edge(e);
    end

    // Threshold edge cases: both ends above it, then one end exactly at it.
    wait_drained();
    write_threshold(16'h0800);
    e = random_edge();
    e.sa = -16'sd500;
    e.sb = 16'sd500;
    e.ua = 16'h0801;
    e.ub = 16'h0801;
    push_edge(e);
    e.ua = 16'h0800;
    e.ub = 16'hFFFF;
    e.last = 1'b1;
    push_edge(e);

    run_setting(16'h0000, PHASE_WORDS);
    run_setting(16'hFFFF, PHASE_WORDS);
    long_hold_req = 1'b1;
    run_setting(16'h1000, PHASE_WORDS);
    run_setting(VAL_W'($urandom), PHASE_WORDS);
    quiet = 1'b1;
    run_setting(16'h8000, PHASE_WORDS);

    wait_drained();
    $display("Run covered %0d edge words in %0d cells, %0d of them with a surface,",
             edges_sent, cells_seen, surfaces_seen);
    $display("under %0d threshold settings, with a %0d-cycle output stall.",
             settings + 1, LONG_HOLD);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
